// ----- design/mad_pkg.sv -----
package mad_pkg;

	localparam int WINDOW_LEN     = 11;
	localparam int PACKET_SAMPLES = 56;

	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 16;
	localparam int COUNT_W  = 8;
	localparam int PACKET_W = 6;
	localparam int POINT_W  = 13;
	localparam int PTR_W    = $clog2(WINDOW_LEN);

	// Reciprocal of the window length, scaled by 2^RECIP_SHIFT and rounded up.
	// The rounding error times the largest sum stays below 2^RECIP_SHIFT, so
	// the product gives the exact truncated quotient for every 16-bit sum.
	localparam int RECIP_SHIFT = 20;
	localparam logic [RECIP_SHIFT-1:0] MEAN_RECIP =
		RECIP_SHIFT'((2 ** RECIP_SHIFT + WINDOW_LEN - 1) / WINDOW_LEN);

	localparam logic [POINT_W-1:0]  POINT_TOP      = POINT_W'(4096);
	localparam logic [COUNT_W-1:0]  RECORD_DEC_RST = COUNT_W'(5);
	localparam logic [COUNT_W-1:0]  DRAW_DEC_RST   = COUNT_W'(4);
	localparam logic [PTR_W-1:0]    PTR_LAST       = PTR_W'(WINDOW_LEN - 1);
	localparam logic [PACKET_W-1:0] PACKET_LAST    = PACKET_W'(PACKET_SAMPLES);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_RECORD_DEC = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAW_DEC   = 1'b1;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_ECG  = 2'd1,
		MODE_PPG  = 2'd2,
		MODE_GSR  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                mode;
		logic [SAMPLE_W-1:0]  ecg_sample;
		logic [SAMPLE_W-1:0]  ppg_sample;
		logic [SAMPLE_W-1:0]  gsr_sample;
	} in_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] mean_value;
		logic                record_strobe;
		logic                draw_strobe;
		logic [POINT_W-1:0]  draw_point;
		logic                rate_strobe;
		logic                packet_end;
	} out_item_t;

	// What the window stage hands to the mean stage for one item.
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             record_strobe;
		logic             draw_strobe;
		logic             ecg_mode;
		logic             gsr_mode;
		logic             packet_end;
	} stage_t;

endpackage

// ----- design/mad_window.sv -----
module mad_window
	import mad_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COUNT_W-1:0]    cfg_data,
	input  logic                  accept,
	input  in_item_t              in_data,
	input  logic                  advance,
	output logic                  stage_valid,
	output stage_t                stage_data
);

	logic [SAMPLE_W-1:0] store_q [WINDOW_LEN];
	logic [PTR_W-1:0]    ptr_q;
	logic [SUM_W-1:0]    sum_q;
	logic [COUNT_W-1:0]  rec_cnt_q;
	logic [COUNT_W-1:0]  draw_cnt_q;
	logic [PACKET_W-1:0] pkt_cnt_q;
	mode_t               prev_mode_q;
	logic [COUNT_W-1:0]  rec_dec_q;
	logic [COUNT_W-1:0]  draw_dec_q;

	logic                valid_s1;
	stage_t              data_s1;

	logic                mode_change;
	logic                has_sample;
	logic [SAMPLE_W-1:0] sample;
	logic [PTR_W-1:0]    ptr_start;
	logic [PTR_W-1:0]    ptr_next;
	logic [COUNT_W-1:0]  rec_start;
	logic [COUNT_W-1:0]  rec_inc;
	logic [COUNT_W-1:0]  draw_inc;
	logic [PACKET_W-1:0] pkt_start;
	logic [PACKET_W-1:0] pkt_inc;
	logic [SUM_W-1:0]    sum_next;
	logic                draw_hit;
	logic                pkt_hit;

	always_comb begin
		mode_change = (in_data.mode != prev_mode_q);
		ptr_start   = mode_change ? '0 : ptr_q;
		rec_start   = mode_change ? '0 : rec_cnt_q;
		pkt_start   = mode_change ? '0 : pkt_cnt_q;

		has_sample = 1'b1;
		case (in_data.mode)
			MODE_ECG: sample = in_data.ecg_sample;
			MODE_PPG: sample = in_data.ppg_sample;
			MODE_GSR: sample = in_data.gsr_sample;
			default: begin
				sample     = '0;
				has_sample = 1'b0;
			end
		endcase

		ptr_next = (ptr_start == PTR_LAST) ? '0 : ptr_start + PTR_W'(1);
		sum_next = sum_q - SUM_W'(store_q[ptr_start]) + SUM_W'(sample);

		rec_inc  = rec_start + COUNT_W'(1);
		draw_inc = draw_cnt_q + COUNT_W'(1);
		draw_hit = (draw_inc >= draw_dec_q);
		pkt_inc  = pkt_start + PACKET_W'(1);
		pkt_hit  = (pkt_inc >= PACKET_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_dec_q  <= RECORD_DEC_RST;
			draw_dec_q <= DRAW_DEC_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RECORD_DEC: rec_dec_q  <= cfg_data;
				CFG_DRAW_DEC:   draw_dec_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				store_q[i] <= '0;
			end
			ptr_q       <= '0;
			sum_q       <= '0;
			rec_cnt_q   <= '0;
			draw_cnt_q  <= '0;
			pkt_cnt_q   <= '0;
			prev_mode_q <= MODE_NONE;
		end else if (accept) begin
			prev_mode_q <= in_data.mode;
			if (has_sample) begin
				store_q[ptr_start] <= sample;
				ptr_q      <= ptr_next;
				sum_q      <= sum_next;
				rec_cnt_q  <= (rec_inc >= rec_dec_q) ? '0 : rec_inc;
				draw_cnt_q <= draw_hit ? '0 : draw_inc;
				pkt_cnt_q  <= pkt_hit ? '0 : pkt_inc;
			end else begin
				// Mode none still restarts the pointer and the record and packet counters on a change.
				ptr_q     <= ptr_start;
				rec_cnt_q <= rec_start;
				pkt_cnt_q <= pkt_start;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= has_sample;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1.sum           <= sum_next;
			data_s1.record_strobe <= (rec_start == '0);
			data_s1.draw_strobe   <= draw_hit;
			data_s1.ecg_mode      <= (in_data.mode == MODE_ECG);
			data_s1.gsr_mode      <= (in_data.mode == MODE_GSR);
			data_s1.packet_end    <= pkt_hit;
		end
	end

	assign stage_valid = valid_s1;
	assign stage_data  = data_s1;

endmodule

// ----- design/mad_mean.sv -----
module mad_mean
	import mad_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      stage_valid,
	input  stage_t    stage_data,
	input  logic      out_stall,
	output logic      advance,
	output logic      out_valid,
	output out_item_t out_data
);

	localparam int PROD_W = SUM_W + RECIP_SHIFT;

	logic                out_valid_q;
	out_item_t           out_data_q;
	logic [PROD_W-1:0]   product;
	logic [SAMPLE_W-1:0] mean;
	logic [POINT_W-1:0]  point;

	always_comb begin
		product = PROD_W'(stage_data.sum) * PROD_W'(MEAN_RECIP);
		mean    = product[RECIP_SHIFT +: SAMPLE_W];
		if (!stage_data.draw_strobe) begin
			point = '0;
		end else if (stage_data.ecg_mode) begin
			point = POINT_TOP - POINT_W'(mean);
		end else begin
			point = POINT_W'(mean);
		end
	end

	// The result register takes a new item whenever it is empty or being read.
	assign advance = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= stage_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && stage_valid) begin
			out_data_q.mean_value    <= mean;
			out_data_q.record_strobe <= stage_data.record_strobe;
			out_data_q.draw_strobe   <= stage_data.draw_strobe;
			out_data_q.draw_point    <= point;
			out_data_q.rate_strobe   <= !stage_data.gsr_mode;
			out_data_q.packet_end    <= stage_data.packet_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- design/moving_average_decimator_top.sv -----
// An accepted item is registered in the window stage, then in the result
// register. Throughput: one item per cycle; input stalls only when the
// window stage and the result register are both full and the result
// is held back.
// Reset clears the window ring, running sum, pointer and counters, sets
// the mode to none and the decimation registers to 5 (record) and 4 (draw).
module moving_average_decimator_top
	import mad_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COUNT_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data
);

	logic   accept;
	logic   advance;
	logic   stage_valid;
	stage_t stage_data;

	assign in_stall = stage_valid && !advance;
	assign accept   = in_valid && !in_stall;

	mad_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.in_data     (in_data),
		.advance     (advance),
		.stage_valid (stage_valid),
		.stage_data  (stage_data)
	);

	mad_mean u_mean (
		.clk         (clk),
		.arst_n      (arst_n),
		.stage_valid (stage_valid),
		.stage_data  (stage_data),
		.out_stall   (out_stall),
		.advance     (advance),
		.out_valid   (out_valid),
		.out_data    (out_data)
	);

endmodule

// ----- design/mad_checker.sv -----
module mad_checker
	import mad_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// A result held back by the receiver stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// The input side only waits when a finished result is itself held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	a_point_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.draw_strobe |-> out_data.draw_point == '0)
		else $error("display point given without display strobe");

	// A display point is the mean itself or its inversion from the top.
	a_point_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.draw_strobe |->
			(out_data.draw_point == POINT_W'(out_data.mean_value)) ||
			(out_data.draw_point == POINT_TOP - POINT_W'(out_data.mean_value)))
		else $error("display point does not follow the mean");

endmodule

bind moving_average_decimator_top mad_checker u_mad_checker (.*);

// ----- tb/sv/moving_average_checker.sv -----
module moving_average_checker
	import mad_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COUNT_W-1:0]   cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_item_t            out_data,
	output int                   failures,
	output int                   outstanding
);

	localparam int TAPS        = 11;
	localparam int PACKET_LEN  = 56;

	logic [SAMPLE_W-1:0] ring [TAPS];
	logic [PTR_W-1:0]    ring_ptr;
	logic [SUM_W-1:0]    ring_sum;
	logic [COUNT_W-1:0]  record_count;
	logic [COUNT_W-1:0]  draw_count;
	logic [COUNT_W-1:0]  record_every;
	logic [COUNT_W-1:0]  draw_every;
	logic [PACKET_W-1:0] packet_count;
	mode_t               last_mode;
	out_item_t           expected_averages [$];

	// Advances the window by one item and gives the result it should produce, if any.
	function automatic bit average_step(input in_item_t item, output out_item_t res);
		logic [SAMPLE_W-1:0] sample;
		logic [SAMPLE_W-1:0] mean;
		res = '0;
		if (item.mode != last_mode) begin
			last_mode = item.mode;
			ring_ptr = '0;
			record_count = '0;
			packet_count = '0;
		end
		case (item.mode)
			MODE_ECG: sample = item.ecg_sample;
			MODE_PPG: sample = item.ppg_sample;
			MODE_GSR: sample = item.gsr_sample;
			default: return 1'b0;
		endcase

		ring_sum = ring_sum - SUM_W'(ring[ring_ptr]) + SUM_W'(sample);
		ring[ring_ptr] = sample;
		ring_ptr = (ring_ptr == PTR_W'(TAPS - 1)) ? '0 : ring_ptr + PTR_W'(1);
		mean = SAMPLE_W'(ring_sum / SUM_W'(TAPS));

		res.record_strobe = (record_count == '0);
		record_count = record_count + COUNT_W'(1);
		if (record_count >= record_every)
			record_count = '0;

		draw_count = draw_count + COUNT_W'(1);
		if (draw_count >= draw_every) begin
			draw_count = '0;
			res.draw_strobe = 1'b1;
		end
		if (res.draw_strobe)
			res.draw_point = (item.mode == MODE_ECG) ? POINT_W'(4096) - POINT_W'(mean)
				: POINT_W'(mean);

		packet_count = packet_count + PACKET_W'(1);
		if (packet_count >= PACKET_W'(PACKET_LEN)) begin
			packet_count = '0;
			res.packet_end = 1'b1;
		end

		res.mean_value = mean;
		res.rate_strobe = (item.mode != MODE_GSR);
		return 1'b1;
	endfunction

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			failures++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++)
				ring[i] = '0;
			ring_ptr = '0;
			ring_sum = '0;
			record_count = '0;
			draw_count = '0;
			packet_count = '0;
			last_mode = MODE_NONE;
			record_every = COUNT_W'(5);
			draw_every = COUNT_W'(4);
			expected_averages.delete();
		end else begin
			// A result can never belong to an item accepted at the same edge.
			if (out_valid && !out_stall) begin
				if (expected_averages.size() == 0) begin
					failures++;
					$display("%0t: result expected none, got %p", $time, out_data);
				end else begin
					want = expected_averages.pop_front();
					check_field("mean_value", 32'(want.mean_value),
						32'(out_data.mean_value));
					check_field("record_strobe", 32'(want.record_strobe),
						32'(out_data.record_strobe));
					check_field("draw_strobe", 32'(want.draw_strobe),
						32'(out_data.draw_strobe));
					check_field("draw_point", 32'(want.draw_point),
						32'(out_data.draw_point));
					check_field("rate_strobe", 32'(want.rate_strobe),
						32'(out_data.rate_strobe));
					check_field("packet_end", 32'(want.packet_end),
						32'(out_data.packet_end));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_RECORD_DEC: record_every = cfg_data;
					CFG_DRAW_DEC: draw_every = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (average_step(in_data, want))
					expected_averages.push_back(want);
			end
		end
		outstanding = expected_averages.size();
	end

endmodule

// ----- tb/sv/tb_moving_average_decimator_top.sv -----
module tb_moving_average_decimator_top;
	import mad_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int PHASES      = 7;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COUNT_W-1:0]   cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_data;
	int                   failures;
	int                   outstanding;
	int                   quiet_cycles;
	bit                   idling_on;

	logic [COUNT_W-1:0] record_plan [PHASES] = '{8'd0, 8'd1, 8'd255, 8'd3, 8'd0, 8'd1, 8'd5};
	logic [COUNT_W-1:0] draw_plan [PHASES]   = '{8'd0, 8'd1, 8'd255, 8'd1, 8'd0, 8'd255, 8'd4};

	moving_average_decimator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	moving_average_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_moving_average_decimator_top: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: stalls come in bursts, with long stretches of none.
	initial begin
		int burst;
		out_stall = 1'b0;
		burst = 0;
		forever begin
			@(negedge clk);
			if (burst == 0 && idling_on && $urandom_range(0, 7) == 0)
				burst = $urandom_range(1, 11);
			if (burst > 0 && idling_on) begin
				out_stall <= 1'b1;
				burst--;
			end else begin
				burst = 0;
				out_stall <= 1'b0;
			end
		end
	end

	function automatic in_item_t item_of(input mode_t m, input logic [SAMPLE_W-1:0] ecg,
			input logic [SAMPLE_W-1:0] ppg, input logic [SAMPLE_W-1:0] gsr);
		in_item_t item;
		item.mode = m;
		item.ecg_sample = ecg;
		item.ppg_sample = ppg;
		item.gsr_sample = gsr;
		return item;
	endfunction

	// Converter values lean towards both ends of the range.
	function automatic logic [SAMPLE_W-1:0] any_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom_range(0, 4095));
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_item(input in_item_t item);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_data <= item;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Waits until every result is out, then lets anything still in flight drain.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic program_decimation(input logic [COUNT_W-1:0] record_every,
			input logic [COUNT_W-1:0] draw_every);
		cfg_we <= 1'b1;
		cfg_index <= CFG_RECORD_DEC;
		cfg_data <= record_every;
		@(negedge clk);
		cfg_index <= CFG_DRAW_DEC;
		cfg_data <= draw_every;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly runs of one mode, some long enough to close a packet, broken up by
	// stretches of mode none and by stray items of any mode.
	task automatic run_phase(input int target);
		int sent;
		int run_len;
		mode_t m;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(0, 9) == 0) begin
				m = MODE_NONE;
				run_len = $urandom_range(1, 3);
			end else begin
				m = mode_t'($urandom_range(1, 3));
				run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(56, 70)
					: $urandom_range(1, 15);
			end
			repeat (run_len) begin
				send_item(item_of(m, any_sample(), any_sample(), any_sample()));
				if (m != MODE_NONE)
					sent++;
			end
			if ($urandom_range(0, 4) == 0)
				send_item(item_of(mode_t'($urandom_range(0, 3)), any_sample(),
					any_sample(), any_sample()));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_RECORD_DEC;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		idling_on = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset decimation values; an ECG display point of a zero window, then a
		// full window at the top of the range, then mode changes in and out of none.
		send_item(item_of(MODE_NONE, 12'd4095, 12'd4095, 12'd4095));
		repeat (4) send_item(item_of(MODE_ECG, 12'd0, 12'd4095, 12'd4095));
		repeat (12) send_item(item_of(MODE_ECG, 12'd4095, 12'd0, 12'd0));
		send_item(item_of(MODE_PPG, 12'd0, 12'd4095, 12'd0));
		send_item(item_of(MODE_GSR, 12'd4095, 12'd0, 12'd4095));
		send_item(item_of(MODE_GSR, 12'd0, 12'd4095, 12'd0));
		send_item(item_of(MODE_NONE, 12'd0, 12'd0, 12'd0));
		send_item(item_of(MODE_GSR, 12'd0, 12'd0, 12'd0));
		send_item(item_of(MODE_PPG, 12'd4095, 12'd4095, 12'd4095));

		record_plan[4] = COUNT_W'($urandom_range(0, 255));
		draw_plan[4] = COUNT_W'($urandom_range(0, 255));
		for (int p = 0; p < PHASES; p++) begin
			settle_block();
			if (p == PHASES - 1)
				idling_on = 1'b0;
			program_decimation(record_plan[p], draw_plan[p]);
			run_phase(32);
		end

		settle_block();
		if (failures == 0 && outstanding == 0) begin
			$display("tb_moving_average_decimator_top: clean");
		end else begin
			$display("tb_moving_average_decimator_top: errors");
		end
		$finish;
	end

endmodule
